@@ src/q3k_pkg.sv @@
package q3k_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int SIG_W  = 51;
  localparam int LEAD_W = 6;

  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [30:0] INF_MAG     = 31'h7F80_0000;

  typedef struct packed {
    logic [7:0]  x_low_bits;
    logic [3:0]  x_high_bits;
    logic [7:0]  gate_low_bits;
    logic [3:0]  gate_high_bits;
    logic [31:0] activations;
    logic [5:0]  x_scale_code;
    logic [5:0]  gate_scale_code;
    logic [15:0] act_scale;
    logic [15:0] x_block_scale;
    logic [15:0] gate_block_scale;
    logic        end_of_block;
    logic        end_of_row;
  } in_item_t;

  typedef struct packed {
    logic [31:0] row_dot_x;
    logic [31:0] row_dot_gate;
  } out_item_t;

  // One classified group waiting for the floating-point back end.
  typedef struct packed {
    logic signed [17:0] x_prod;
    logic signed [17:0] g_prod;
    logic [15:0]        act_scale;
    logic [15:0]        x_bs;
    logic [15:0]        g_bs;
    logic               close_blk;
    logic               eor;
  } qent_t;

  typedef enum logic {FP_ADD = 1'b0, FP_MUL = 1'b1} fp_op_t;

  // Operand as value = sig * 2^q, with class flags and its fp32 pattern.
  typedef struct packed {
    logic              sign;
    logic              is_nan;
    logic              is_inf;
    logic [23:0]       sig;
    logic signed [9:0] q;
    logic [31:0]       bits;
  } fp_opnd_t;

  typedef struct packed {
    logic     valid;
    fp_op_t   op;
    logic     is_gate;
    fp_opnd_t a;
    fp_opnd_t b;
  } fp_req_t;

  typedef struct packed {
    logic        valid;
    logic        is_gate;
    logic [31:0] bits;
  } fp_res_t;

  // Exact unrounded result, or a finished pattern when direct is set.
  typedef struct packed {
    logic               sign;
    logic               direct;
    logic [31:0]        bits;
    logic [SIG_W-1:0]   sig;
    logic signed [11:0] q;
  } raw_t;

  function automatic fp_opnd_t unpack_half(input logic [15:0] h);
    fp_opnd_t o;
    o.sign   = h[15];
    o.is_nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    o.is_inf = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
    o.bits   = {h[15], 8'hFF, h[9:0], 13'b0};
    if (h[14:10] == 5'd0) begin
      o.sig = {14'b0, h[9:0]};
      o.q   = -10'sd24;
    end else begin
      o.sig = {13'b0, 1'b1, h[9:0]};
      o.q   = $signed({5'b0, h[14:10]}) - 10'sd25;
    end
    return o;
  endfunction

  function automatic fp_opnd_t unpack_f32(input logic [31:0] b);
    fp_opnd_t o;
    o.sign   = b[31];
    o.is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    o.is_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    o.bits   = b;
    if (b[30:23] == 8'd0) begin
      o.sig = {1'b0, b[22:0]};
      o.q   = -10'sd149;
    end else begin
      o.sig = {1'b1, b[22:0]};
      o.q   = $signed({2'b0, b[30:23]}) - 10'sd150;
    end
    return o;
  endfunction

  function automatic fp_opnd_t unpack_int(input logic signed [17:0] v);
    fp_opnd_t   o;
    logic [17:0] mag;
    mag      = v[17] ? 18'(-v) : 18'(v);
    o.sign   = v[17];
    o.is_nan = 1'b0;
    o.is_inf = 1'b0;
    o.sig    = {6'b0, mag};
    o.q      = 10'sd0;
    o.bits   = 32'd0;
    return o;
  endfunction

  // Special cases follow the usual SSE rules: the first NaN operand wins.
  function automatic raw_t fp_stage1(input fp_op_t op, input fp_opnd_t a,
                                     input fp_opnd_t b);
    raw_t              rw;
    logic              zero_a, zero_b, sx, swap, lost;
    fp_opnd_t          big, sml;
    logic signed [10:0] dd;
    logic [47:0]       prod;
    logic [SIG_W-1:0]  bx, s0, ss, sm;
    rw     = '0;
    zero_a = (a.sig == 24'd0);
    zero_b = (b.sig == 24'd0);
    sx     = a.sign ^ b.sign;
    swap   = b.bits[30:0] > a.bits[30:0];
    big    = swap ? b : a;
    sml    = swap ? a : b;
    dd     = 11'(big.q) - 11'(sml.q);
    prod   = a.sig * b.sig;
    bx     = {1'b0, big.sig, 26'b0};
    s0     = {1'b0, sml.sig, 26'b0};
    ss     = '0;
    lost   = 1'b0;
    if (dd > 11'sd50) begin
      sm = {{(SIG_W-1){1'b0}}, 1'b1};
    end else begin
      ss   = s0 >> 6'(dd);
      lost = (ss << 6'(dd)) != s0;
      sm   = ss | {{(SIG_W-1){1'b0}}, lost};
    end
    if (a.is_nan) begin
      rw.direct = 1'b1;
      rw.bits   = a.bits | QUIET_BIT;
    end else if (b.is_nan) begin
      rw.direct = 1'b1;
      rw.bits   = b.bits | QUIET_BIT;
    end else if (op == FP_MUL) begin
      rw.direct = 1'b1;
      if ((a.is_inf && zero_b) || (b.is_inf && zero_a)) begin
        rw.bits = DEFAULT_NAN;
      end else if (a.is_inf || b.is_inf) begin
        rw.bits = {sx, INF_MAG};
      end else if (zero_a || zero_b) begin
        rw.bits = {sx, 31'd0};
      end else begin
        rw.direct = 1'b0;
        rw.sign   = sx;
        rw.sig    = {3'b0, prod};
        rw.q      = 12'(a.q) + 12'(b.q);
      end
    end else begin
      rw.direct = 1'b1;
      if (a.is_inf && b.is_inf && (a.sign != b.sign)) begin
        rw.bits = DEFAULT_NAN;
      end else if (a.is_inf) begin
        rw.bits = a.bits;
      end else if (b.is_inf) begin
        rw.bits = b.bits;
      end else if (zero_a && zero_b) begin
        rw.bits = {a.sign & b.sign, 31'd0};
      end else if (zero_a) begin
        rw.bits = b.bits;
      end else if (zero_b) begin
        rw.bits = a.bits;
      end else begin
        rw.direct = 1'b0;
        rw.sign   = big.sign;
        rw.sig    = (big.sign == sml.sign) ? bx + sm : bx - sm;
        rw.q      = 12'(big.q) - 12'sd26;
      end
    end
    return rw;
  endfunction

  function automatic logic [LEAD_W-1:0] lead_one(input logic [SIG_W-1:0] s);
    logic [LEAD_W-1:0] l;
    l = '0;
    for (int i = 0; i < SIG_W; i++) begin
      if (s[i]) l = LEAD_W'(i);
    end
    return l;
  endfunction

  // Round to nearest even; subnormal and overflow ranges fall out of the packing.
  function automatic logic [31:0] fp_round(input raw_t rw, input logic [LEAD_W-1:0] lead);
    logic signed [12:0] rn, rs, r, expf;
    logic [5:0]         rc;
    logic [4:0]         ls;
    logic [SIG_W:0]     ext, sh;
    logic [23:0]        mant;
    logic               g, st, rnd;
    logic [35:0]        pk;
    logic [31:0]        res;
    rn  = $signed({7'b0, lead}) - 13'sd23;
    rs  = -13'(rw.q) - 13'sd149;
    r   = (rn > rs) ? rn : rs;
    ext = {rw.sig, 1'b0};
    if (r < 0) begin
      ls   = 5'(-r);
      mant = rw.sig[23:0] << ls;
      g    = 1'b0;
      st   = 1'b0;
      rc   = '0;
      sh   = '0;
    end else begin
      ls   = '0;
      rc   = (r > 13'sd52) ? 6'd52 : 6'(r);
      sh   = ext >> rc;
      mant = sh[24:1];
      g    = sh[0];
      st   = (sh << rc) != ext;
    end
    rnd  = g & (st | mant[0]);
    expf = r + 13'(rw.q) + 13'sd149;
    pk   = ({23'b0, expf} << 23) + {12'b0, mant} + {35'b0, rnd};
    if (rw.direct) begin
      res = rw.bits;
    end else if (rw.sig == '0) begin
      res = 32'd0;
    end else if (pk >= {5'b0, INF_MAG}) begin
      res = {rw.sign, INF_MAG};
    end else begin
      res = {rw.sign, pk[30:0]};
    end
    return res;
  endfunction

endpackage

@@ src/q3k_in_if.sv @@
interface q3k_in_if;
  logic                valid;
  logic                ready;
  q3k_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/q3k_out_if.sv @@
interface q3k_out_if;
  logic                valid;
  logic                ready;
  q3k_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/q3k_front.sv @@
module q3k_front (
  q3k_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output q3k_pkg::qent_t  q_wdata
);

  // A clear high bit means the weight is its low part minus 4, which is the
  // 3-bit two's complement value {~high, low}. Likewise code - 32 is the
  // 6-bit code with its top bit flipped.
  function automatic logic signed [17:0] group_product(input logic [7:0] low,
                                                       input logic [3:0] high,
                                                       input logic [31:0] act,
                                                       input logic [5:0] code);
    logic signed [12:0] acc;
    logic signed [2:0]  w;
    logic signed [7:0]  av;
    logic signed [5:0]  sc;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      w   = $signed({~high[k], low[2*k +: 2]});
      av  = $signed(act[8*k +: 8]);
      acc = acc + 13'(w) * 13'(av);
    end
    sc = $signed({~code[5], code[4:0]});
    return 18'(acc) * 18'(sc);
  endfunction

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    q_wdata.x_prod    = group_product(in_ch.data.x_low_bits, in_ch.data.x_high_bits,
                                      in_ch.data.activations, in_ch.data.x_scale_code);
    q_wdata.g_prod    = group_product(in_ch.data.gate_low_bits, in_ch.data.gate_high_bits,
                                      in_ch.data.activations, in_ch.data.gate_scale_code);
    q_wdata.act_scale = in_ch.data.act_scale;
    q_wdata.x_bs      = in_ch.data.x_block_scale;
    q_wdata.g_bs      = in_ch.data.gate_block_scale;
    // A row end closes the open block as well.
    q_wdata.close_blk = in_ch.data.end_of_block || in_ch.data.end_of_row;
    q_wdata.eor       = in_ch.data.end_of_row;
  end

endmodule

@@ src/q3k_queue.sv @@
module q3k_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  q3k_pkg::qent_t  wdata,
  input  logic            pop,
  output q3k_pkg::qent_t  rdata,
  output logic            full,
  output logic            not_empty
);

  q3k_pkg::qent_t                mem_r [q3k_pkg::QDEPTH];
  logic [q3k_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [q3k_pkg::QPTR_W:0]      cnt_r, cnt_nxt;

  assign cnt_nxt   = cnt_r + {{q3k_pkg::QPTR_W{1'b0}}, push}
                           - {{q3k_pkg::QPTR_W{1'b0}}, pop};
  assign full      = (cnt_r == (q3k_pkg::QPTR_W+1)'(q3k_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

@@ src/q3k_fpu.sv @@
module q3k_fpu (
  input  logic              clk,
  input  logic              rst_n,
  input  q3k_pkg::fp_req_t  req,
  output q3k_pkg::fp_res_t  res
);

  // Three stages: multiply or align-and-add, leading-one search, round and pack.
  logic                              s1_valid_r, s1_gate_r;
  q3k_pkg::raw_t                     s1_raw_r;
  logic                              s2_valid_r, s2_gate_r;
  q3k_pkg::raw_t                     s2_raw_r;
  logic [q3k_pkg::LEAD_W-1:0]        s2_lead_r;
  logic                              res_valid_r, res_gate_r;
  logic [31:0]                       res_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= req.valid;
      s2_valid_r  <= s1_valid_r;
      res_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_gate_r  <= req.is_gate;
    s1_raw_r   <= q3k_pkg::fp_stage1(req.op, req.a, req.b);
    s2_gate_r  <= s1_gate_r;
    s2_raw_r   <= s1_raw_r;
    s2_lead_r  <= q3k_pkg::lead_one(s1_raw_r.sig);
    res_gate_r <= s2_gate_r;
    res_bits_r <= q3k_pkg::fp_round(s2_raw_r, s2_lead_r);
  end

  assign res.valid   = res_valid_r;
  assign res.is_gate = res_gate_r;
  assign res.bits    = res_bits_r;

endmodule

@@ src/q3k_back.sv @@
module q3k_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  q3k_pkg::qent_t    q_data,
  output logic              q_pop,
  output q3k_pkg::fp_req_t  fp_req,
  input  q3k_pkg::fp_res_t  fp_res,
  q3k_out_if.source         out_ch
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MULP = 6'b000010,
    ST_ADDP = 6'b000100,
    ST_MULB = 6'b001000,
    ST_ADDR = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  localparam logic [1:0] PH_X    = 2'd0;
  localparam logic [1:0] PH_G    = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;

  state_t              state_r, state_nxt;
  logic [1:0]          phase_r;
  q3k_pkg::qent_t      cur_r;
  logic [31:0]         px_r, pg_r, bx_r, bg_r;
  logic [31:0]         xpart_r, gpart_r, xrow_r, grow_r;
  logic                out_valid_r;
  q3k_pkg::out_item_t  out_data_r;
  logic                compute, phase_done, out_load, gsel;

  assign compute    = (state_r == ST_MULP) || (state_r == ST_ADDP) ||
                      (state_r == ST_MULB) || (state_r == ST_ADDR);
  // Each phase issues the x operation, then the gate one; the gate result ends it.
  assign phase_done = fp_res.valid && fp_res.is_gate;
  assign out_load   = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign gsel       = (phase_r == PH_G);

  always_comb begin
    fp_req         = '0;
    fp_req.valid   = compute && (phase_r != PH_WAIT);
    fp_req.is_gate = gsel;
    unique case (state_r)
      ST_MULP: begin
        fp_req.op = q3k_pkg::FP_MUL;
        fp_req.a  = q3k_pkg::unpack_half(cur_r.act_scale);
        fp_req.b  = q3k_pkg::unpack_int(gsel ? cur_r.g_prod : cur_r.x_prod);
      end
      ST_ADDP: begin
        fp_req.op = q3k_pkg::FP_ADD;
        fp_req.a  = q3k_pkg::unpack_f32(gsel ? gpart_r : xpart_r);
        fp_req.b  = q3k_pkg::unpack_f32(gsel ? pg_r : px_r);
      end
      ST_MULB: begin
        fp_req.op = q3k_pkg::FP_MUL;
        fp_req.a  = q3k_pkg::unpack_half(gsel ? cur_r.g_bs : cur_r.x_bs);
        fp_req.b  = q3k_pkg::unpack_f32(gsel ? gpart_r : xpart_r);
      end
      ST_ADDR: begin
        fp_req.op = q3k_pkg::FP_ADD;
        fp_req.a  = q3k_pkg::unpack_f32(gsel ? grow_r : xrow_r);
        fp_req.b  = q3k_pkg::unpack_f32(gsel ? bg_r : bx_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = ST_MULP;
        end
      end
      ST_MULP: if (phase_done) state_nxt = ST_ADDP;
      ST_ADDP: if (phase_done) state_nxt = cur_r.close_blk ? ST_MULB : ST_IDLE;
      ST_MULB: if (phase_done) state_nxt = ST_ADDR;
      ST_ADDR: if (phase_done) state_nxt = cur_r.eor ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_X;
      out_valid_r <= 1'b0;
      xpart_r     <= 32'd0;
      gpart_r     <= 32'd0;
      xrow_r      <= 32'd0;
      grow_r      <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        phase_r <= PH_X;
      end else if (compute && (phase_r != PH_WAIT)) begin
        phase_r <= phase_r + 2'd1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (fp_res.valid && (state_r == ST_ADDP)) begin
        if (fp_res.is_gate) gpart_r <= fp_res.bits;
        else xpart_r <= fp_res.bits;
      end
      // The partials have been scaled into bx/bg; the block starts over.
      if (phase_done && (state_r == ST_MULB)) begin
        xpart_r <= 32'd0;
        gpart_r <= 32'd0;
      end
      if (fp_res.valid && (state_r == ST_ADDR)) begin
        if (fp_res.is_gate) grow_r <= fp_res.bits;
        else xrow_r <= fp_res.bits;
      end
      if (out_load) begin
        xrow_r <= 32'd0;
        grow_r <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
    if (fp_res.valid && (state_r == ST_MULP)) begin
      if (fp_res.is_gate) pg_r <= fp_res.bits;
      else px_r <= fp_res.bits;
    end
    if (fp_res.valid && (state_r == ST_MULB)) begin
      if (fp_res.is_gate) bg_r <= fp_res.bits;
      else bx_r <= fp_res.bits;
    end
    if (out_load) begin
      out_data_r.row_dot_x    <= xrow_r;
      out_data_r.row_dot_gate <= grow_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_res_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    fp_res.valid |-> (state_r == ST_MULP || state_r == ST_ADDP ||
                      state_r == ST_MULB || state_r == ST_ADDR))
    else $error("floating-point result arrived outside a compute phase");

  a_emit_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> cur_r.eor)
    else $error("emitting for an item that does not end a row");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result appeared without passing through the emit state");

endmodule

@@ src/q3k_pair_dot_accumulator.sv @@
// Channel | Direction | Handshake   | Payload
// in_ch   | input     | valid/ready | q3k_pkg::in_item_t, one group of four weights per matrix
// out_ch  | output    | valid/ready | q3k_pkg::out_item_t, both row sums, only on row end
//
// The back end runs a group through a multiply and an add phase; closing a block adds a scale and a row
// add, and a row end then the emit state. Each phase passes twice through the shared three-stage fp32 unit.
// rst_n is synchronous; it clears the block partials, the row sums and all control state.
// A four-entry queue lets in_ch keep accepting while the back end works.
// The output register holds a result while the following groups go on.
module q3k_pair_dot_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  q3k_in_if.sink      in_ch,
  q3k_out_if.source   out_ch
);

  logic              push, pop, q_full, q_not_empty;
  q3k_pkg::qent_t    q_wdata, q_rdata;
  q3k_pkg::fp_req_t  fp_req;
  q3k_pkg::fp_res_t  fp_res;

  q3k_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .push    (push),
    .q_wdata (q_wdata)
  );

  q3k_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (q_wdata),
    .pop       (pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  q3k_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fp_req),
    .res   (fp_res)
  );

  q3k_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_data  (q_rdata),
    .q_pop   (pop),
    .fp_req  (fp_req),
    .fp_res  (fp_res),
    .out_ch  (out_ch)
  );

endmodule
